/* rtl/core/hsp_pkg.sv */
package hsp_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       is_last;
    } t_in_beat;

    typedef struct packed {
        logic        ok;
        logic [63:0] value;
    } t_out_beat;

    typedef struct packed {
        logic take;
        logic emit;
    } t_stage_ctl;

    typedef enum logic [5:0] {
        PH_LEAD   = 6'b000001,
        PH_ZERO   = 6'b000010,
        PH_PREFIX = 6'b000100,
        PH_DIGITS = 6'b001000,
        PH_TRAIL  = 6'b010000,
        PH_BAD    = 6'b100000
    } t_phase;

    localparam logic [7:0] C_TAB       = 8'd9;
    localparam logic [7:0] C_CR        = 8'd13;
    localparam logic [7:0] C_SPACE     = 8'd32;
    localparam logic [7:0] C_DOLLAR    = 8'h24;
    localparam logic [7:0] C_ZERO      = 8'h30;
    localparam logic [7:0] C_NINE      = 8'h39;
    localparam logic [7:0] C_LO_A      = 8'h61;
    localparam logic [7:0] C_LO_F      = 8'h66;
    localparam logic [7:0] C_UP_A      = 8'h41;
    localparam logic [7:0] C_UP_F      = 8'h46;
    localparam logic [7:0] C_LO_X      = 8'h78;
    localparam logic [7:0] C_UP_X      = 8'h58;
    localparam logic [7:0] C_TEN       = 8'd10;
    localparam logic [63:0] C_MAX_RST  = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

/* rtl/core/hex_string_parser_core.sv */
// Hex string parser: one ASCII character per input beat, one verdict per string.
// Input channel (i_in_valid / o_in_stall / i_in): each beat carries a character,
// a has_char flag (clear for a beat with no character, e.g. an empty string)
// and is_last, which closes the string. Output channel (o_out_valid /
// i_out_stall / o_out): one beat per string with ok and value; value is zero
// when ok is clear. Configuration channel (i_cfg_valid / o_cfg_ready /
// i_cfg_data) writes the value ceiling; write it only while no string is in flight.
// A last beat is registered in the input stage; its result is then loaded into the
// output register once that is free, and is offered to the receiver from there.
// Throughput: one character per cycle while o_in_stall is low, set by the update of the
// parse phase and the 64-bit accumulator with its subtract-and-shift range check.
// Reset (synchronous, i_rst_n low) empties both stages, returns the parser to
// the leading-whitespace phase with a zero accumulator, and sets the ceiling to
// all ones. When the receiver stalls, the result is held in the output
// register; the input keeps taking non-last beats, and a last beat waits in
// the input register, which raises o_in_stall for the following beat.
module hex_string_parser_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hsp_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hsp_pkg::t_out_beat o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [63:0]        i_cfg_data
);

    logic [63:0]         r_ceiling;
    logic                stg_valid;
    hsp_pkg::t_in_beat   stg_beat;
    hsp_pkg::t_out_beat  res;
    hsp_pkg::t_stage_ctl ctl;
    logic                out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= hsp_pkg::C_MAX_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ceiling <= i_cfg_data;
        end
    end

    always_comb begin
        ctl.take = stg_valid && (!stg_beat.is_last || out_free);
        ctl.emit = ctl.take && stg_beat.is_last;
    end

    hsp_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_ctl      (ctl),
        .o_in_stall (o_in_stall),
        .o_valid    (stg_valid),
        .o_beat     (stg_beat)
    );

    hsp_parse_step u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_beat    (stg_beat),
        .i_ceiling (r_ceiling),
        .o_res     (res)
    );

    hsp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.ok) |-> (o_out.value == 64'd0))
        else $error("invalid result carries a nonzero value");

    a_within_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.ok) |-> (o_out.value <= r_ceiling))
        else $error("accepted value exceeds the ceiling");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !stg_valid |-> !o_in_stall)
        else $error("input stalled with an empty input stage");

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !ctl.emit)
        else $error("result written over a held output beat");

endmodule

/* rtl/core/hsp_in_stage.sv */
module hsp_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  hsp_pkg::t_in_beat  i_in,
    input  hsp_pkg::t_stage_ctl i_ctl,
    output logic               o_in_stall,
    output logic               o_valid,
    output hsp_pkg::t_in_beat  o_beat
);

    logic              r_valid;
    logic              n_valid;
    hsp_pkg::t_in_beat r_beat;
    logic              accept;

    assign o_in_stall = r_valid && !i_ctl.take;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_valid    = accept || (r_valid && !i_ctl.take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat <= i_in;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

/* rtl/core/hsp_parse_step.sv */
module hsp_parse_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hsp_pkg::t_stage_ctl i_ctl,
    input  hsp_pkg::t_in_beat   i_beat,
    input  logic [63:0]         i_ceiling,
    output hsp_pkg::t_out_beat  o_res
);

    hsp_pkg::t_phase r_phase;
    hsp_pkg::t_phase n_phase;
    hsp_pkg::t_phase ph_c;
    logic [63:0]     r_acc;
    logic [63:0]     n_acc;
    logic [63:0]     acc_c;
    logic [7:0]      c;
    logic            is_ws;
    logic            is_dig;
    logic [3:0]      dig;
    logic [63:0]     dig_w;
    logic [63:0]     room;
    logic            fits;
    logic            good;

    assign c     = i_beat.ch;
    assign is_ws = ((c >= hsp_pkg::C_TAB) && (c <= hsp_pkg::C_CR)) || (c == hsp_pkg::C_SPACE);

    always_comb begin
        is_dig = 1'b1;
        dig    = 4'd0;
        if ((c >= hsp_pkg::C_ZERO) && (c <= hsp_pkg::C_NINE)) begin
            dig = 4'(c - hsp_pkg::C_ZERO);
        end else if ((c >= hsp_pkg::C_LO_A) && (c <= hsp_pkg::C_LO_F)) begin
            dig = 4'(c - hsp_pkg::C_LO_A + hsp_pkg::C_TEN);
        end else if ((c >= hsp_pkg::C_UP_A) && (c <= hsp_pkg::C_UP_F)) begin
            dig = 4'(c - hsp_pkg::C_UP_A + hsp_pkg::C_TEN);
        end else begin
            is_dig = 1'b0;
        end
    end

    // value * 16 + d stays within max when d <= max and acc <= (max - d) / 16
    assign dig_w = {60'd0, dig};
    assign room  = (i_ceiling - dig_w) >> 4;
    assign fits  = (dig_w <= i_ceiling) && (r_acc <= room);

    always_comb begin
        ph_c  = r_phase;
        acc_c = r_acc;
        if (i_beat.has_char) begin
            unique case (r_phase)
                hsp_pkg::PH_LEAD: begin
                    if (is_ws) begin
                        ph_c = hsp_pkg::PH_LEAD;
                    end else if (c == hsp_pkg::C_DOLLAR) begin
                        ph_c = hsp_pkg::PH_PREFIX;
                    end else if (c == hsp_pkg::C_ZERO) begin
                        ph_c = hsp_pkg::PH_ZERO;
                    end else if (is_dig) begin
                        ph_c = fits ? hsp_pkg::PH_DIGITS : hsp_pkg::PH_BAD;
                    end else begin
                        ph_c = hsp_pkg::PH_BAD;
                    end
                end
                hsp_pkg::PH_ZERO: begin
                    if ((c == hsp_pkg::C_LO_X) || (c == hsp_pkg::C_UP_X)) begin
                        ph_c = hsp_pkg::PH_PREFIX;
                    end else if (is_ws) begin
                        ph_c = hsp_pkg::PH_TRAIL;
                    end else if (is_dig) begin
                        ph_c = fits ? hsp_pkg::PH_DIGITS : hsp_pkg::PH_BAD;
                    end else begin
                        ph_c = hsp_pkg::PH_BAD;
                    end
                end
                hsp_pkg::PH_PREFIX, hsp_pkg::PH_DIGITS: begin
                    if (is_dig) begin
                        ph_c = fits ? hsp_pkg::PH_DIGITS : hsp_pkg::PH_BAD;
                    end else if ((r_phase == hsp_pkg::PH_DIGITS) && is_ws) begin
                        ph_c = hsp_pkg::PH_TRAIL;
                    end else begin
                        ph_c = hsp_pkg::PH_BAD;
                    end
                end
                hsp_pkg::PH_TRAIL: begin
                    ph_c = is_ws ? hsp_pkg::PH_TRAIL : hsp_pkg::PH_BAD;
                end
                default: begin
                    ph_c = hsp_pkg::PH_BAD;
                end
            endcase
            if (is_dig && fits && (r_phase != hsp_pkg::PH_TRAIL) && (r_phase != hsp_pkg::PH_BAD)
                && !((r_phase == hsp_pkg::PH_LEAD) && (c == hsp_pkg::C_ZERO))) begin
                acc_c = {r_acc[59:0], dig};
            end
        end
    end

    assign good = (ph_c == hsp_pkg::PH_ZERO) || (ph_c == hsp_pkg::PH_DIGITS)
                  || (ph_c == hsp_pkg::PH_TRAIL);

    always_comb begin
        o_res.ok    = good;
        o_res.value = good ? acc_c : 64'd0;
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        if (i_ctl.take) begin
            if (i_beat.is_last) begin
                n_phase = hsp_pkg::PH_LEAD;
                n_acc   = 64'd0;
            end else begin
                n_phase = ph_c;
                n_acc   = acc_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hsp_pkg::PH_LEAD;
            r_acc   <= 64'd0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

endmodule

/* rtl/core/hsp_out_stage.sv */
module hsp_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hsp_pkg::t_stage_ctl i_ctl,
    input  hsp_pkg::t_out_beat  i_res,
    input  logic                i_out_stall,
    output logic                o_free,
    output logic                o_out_valid,
    output hsp_pkg::t_out_beat  o_out
);

    logic               r_valid;
    logic               n_valid;
    hsp_pkg::t_out_beat r_out;

    assign o_free  = !r_valid || !i_out_stall;
    assign n_valid = i_ctl.emit || (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule
